>>> design/i2k_pkg.sv
// shared types and byte constants for the iso-2022-kr to euc-kr decoder
// no dependencies; imported by the front, queue, back and top modules
package i2k_pkg;

  localparam logic [7:0] ESC_BYTE    = 8'h1b;
  localparam logic [7:0] SO_BYTE     = 8'h0e;
  localparam logic [7:0] SI_BYTE     = 8'h0f;
  localparam logic [7:0] DOLLAR_BYTE = 8'h24;
  localparam logic [7:0] PAREN_BYTE  = 8'h29;
  localparam logic [7:0] C_BYTE      = 8'h43;
  localparam logic [7:0] HIGH_BIT    = 8'h80;
  localparam logic [7:0] LOW_MASK    = 8'h7f;

  localparam int unsigned JOB_BYTES = 4;

  // bytes of one input's output run, first byte in slot 0
  typedef struct packed {
    logic [1:0]                 last_idx;
    logic [JOB_BYTES-1:0][7:0]  bytes;
  } job_t;

endpackage

>>> design/i2k_front.sv
// front end: decodes one input byte per cycle while in_accept is high,
// against the escape/shift state; depends on i2k_pkg; pushes output-run jobs
module i2k_front
  import i2k_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_accept,
  input  logic [7:0] in_byte,
  output logic       job_push,
  output job_t       job
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_DOLLAR,
    PH_PAREN
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic       designated_r, designated_nxt;
  logic       shifted_r, shifted_nxt;
  logic       lead_pend_r, lead_pend_nxt;
  logic [7:0] lead_val_r, lead_val_nxt;
  logic [2:0] n_bytes;

  always_comb begin
    phase_nxt      = phase_r;
    designated_nxt = designated_r;
    shifted_nxt    = shifted_r;
    lead_pend_nxt  = lead_pend_r;
    lead_val_nxt   = lead_val_r;
    n_bytes        = 3'd0;
    job.bytes      = '0;
    unique case (phase_r)
      PH_ESC: begin
        if (in_byte == DOLLAR_BYTE) begin
          phase_nxt = PH_DOLLAR;
        end else begin
          job.bytes[0] = ESC_BYTE;
          job.bytes[1] = in_byte;
          n_bytes      = 3'd2;
          phase_nxt    = PH_IDLE;
        end
      end
      PH_DOLLAR: begin
        if (in_byte == PAREN_BYTE) begin
          phase_nxt = PH_PAREN;
        end else begin
          job.bytes[0] = ESC_BYTE;
          job.bytes[1] = DOLLAR_BYTE;
          job.bytes[2] = in_byte;
          n_bytes      = 3'd3;
          phase_nxt    = PH_IDLE;
        end
      end
      PH_PAREN: begin
        if (in_byte == C_BYTE) begin
          designated_nxt = 1'b1;
        end else begin
          job.bytes[0] = ESC_BYTE;
          job.bytes[1] = DOLLAR_BYTE;
          job.bytes[2] = PAREN_BYTE;
          job.bytes[3] = in_byte;
          n_bytes      = 3'd4;
        end
        phase_nxt = PH_IDLE;
      end
      default: begin
        // a held lead byte takes the next byte as trail, whatever it is
        if (lead_pend_r) begin
          job.bytes[0]  = lead_val_r | HIGH_BIT;
          job.bytes[1]  = in_byte | HIGH_BIT;
          n_bytes       = 3'd2;
          lead_pend_nxt = 1'b0;
        end else if (in_byte == ESC_BYTE) begin
          phase_nxt = PH_ESC;
        end else if (in_byte == SO_BYTE) begin
          shifted_nxt = 1'b1;
        end else if (in_byte == SI_BYTE) begin
          shifted_nxt = 1'b0;
        end else if (designated_r && shifted_r) begin
          lead_val_nxt  = in_byte;
          lead_pend_nxt = 1'b1;
        end else begin
          job.bytes[0] = in_byte & LOW_MASK;
          n_bytes      = 3'd1;
        end
      end
    endcase
    job.last_idx = 2'(n_bytes - 3'd1);
    job_push     = in_accept && (n_bytes != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      designated_r <= 1'b0;
      shifted_r    <= 1'b0;
      lead_pend_r  <= 1'b0;
    end else if (in_accept) begin
      phase_r      <= phase_nxt;
      designated_r <= designated_nxt;
      shifted_r    <= shifted_nxt;
      lead_pend_r  <= lead_pend_nxt;
    end
    if (in_accept) begin
      lead_val_r <= lead_val_nxt;
    end
  end

endmodule

>>> design/i2k_queue.sv
// small job queue between front and back, register based
// depends on i2k_pkg for the job type
module i2k_queue
  import i2k_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output job_t head_job
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> design/i2k_back.sv
// back end: walks the bytes of each queued job onto the output stream
// depends on i2k_pkg for the job type
module i2k_back
  import i2k_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_not_empty,
  input  job_t       q_head,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  job_t       cur_r;
  logic [1:0] idx_r;
  logic       valid_r;
  logic       at_last;
  logic       done;

  assign at_last = (idx_r == cur_r.last_idx);
  // current job finishes this cycle, or there is none
  assign done    = !valid_r || (out_tready && at_last);
  assign q_pop   = q_not_empty && done;

  assign out_tvalid = valid_r;
  assign out_byte   = cur_r.bytes[idx_r];
  assign out_last   = at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (done) begin
      valid_r <= q_not_empty;
      idx_r   <= '0;
    end else if (out_tready) begin
      idx_r <= idx_r + 2'd1;
    end
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

endmodule

>>> design/iso2022kr_to_euckr_decoder_top.sv
// iso-2022-kr to euc-kr decoder; front decode, job queue, back serializer
// an accepted input's job is registered in the queue, then in the back, before its first byte is valid
// throughput: one input per cycle while the queue is not full; an input yielding k bytes
// sends them one per output handshake; QUEUE_DEPTH queued jobs absorb escape pass-through bursts
// reset: synchronous active-low rst_n clears shift, designation, escape and lead state
module iso2022kr_to_euckr_decoder_top
  import i2k_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast    // last_of_run
);

  logic in_accept;
  logic job_push;
  job_t job;
  logic q_full;
  logic q_not_empty;
  logic q_pop;
  job_t q_head;

  assign in_tready = rst_n && !q_full;
  assign in_accept = in_tvalid && in_tready;

  i2k_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_byte   (in_tdata),
    .job_push  (job_push),
    .job       (job)
  );

  i2k_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (q_head)
  );

  i2k_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_byte    (out_tdata),
    .out_last    (out_tlast)
  );

endmodule

>>> design/i2k_checker.sv
// port-level checks for the decoder top level, attached by bind
// depends only on the top level's ports
module i2k_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  logic seen_in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_in_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      seen_in_r <= 1'b1;
    end
  end

  // stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // nothing leaves before some item came in
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> seen_in_r)
    else $error("output item without any accepted input");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // queue is empty after reset, so input is taken at once
  a_ready_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_tready)
    else $error("input not ready after reset");

endmodule

bind iso2022kr_to_euckr_decoder_top i2k_checker u_i2k_checker (.*);

>>> tb/sv/tb_top.sv
// self-checking testbench for the iso-2022-kr to euc-kr decoder: a directed table, then random
// escape, shift and double-byte sequences; depends on i2k_pkg and iso2022kr_to_euckr_decoder_top
module tb_top
  import i2k_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 350;
  localparam int DIR_ROWS       = 30;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_PRINTED    = 20;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_GOT_ESC,
    ESC_GOT_DOLLAR,
    ESC_GOT_PAREN
  } esc_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } euc_item_t;

  // typed rows carry their own expected bytes, first byte in the top bits
  typedef struct packed {
    logic [7:0]  in_b;
    logic        typed;
    logic [2:0]  cnt;
    logic [31:0] bytes;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;

  // expectation that travels with the item being driven
  logic        drv_typed;
  logic [2:0]  drv_cnt;
  logic [31:0] drv_bytes;

  // decoder state as the testbench sees it
  logic       kr_designated = 1'b0;
  logic       kr_shifted    = 1'b0;
  esc_phase_t esc_phase     = ESC_NONE;
  logic       lead_held     = 1'b0;
  logic [7:0] lead_byte     = 8'h00;

  euc_item_t euc_expected_q[$];
  int        err_count = 0;
  int        idle_cycles = 0;
  int        in_burst_left = 0;
  dir_row_t  dir_tbl [DIR_ROWS];

  iso2022kr_to_euckr_decoder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // returns how many euc-kr bytes one iso-2022-kr byte produces
  function automatic int decode_iso_byte(input logic [7:0] b, output logic [3:0][7:0] res);
    int n;
    n = 0;
    res = '0;
    if (esc_phase == ESC_GOT_ESC) begin
      if (b == DOLLAR_BYTE) begin
        esc_phase = ESC_GOT_DOLLAR;
      end else begin
        res[0] = ESC_BYTE;
        res[1] = b;
        n = 2;
        esc_phase = ESC_NONE;
      end
    end else if (esc_phase == ESC_GOT_DOLLAR) begin
      if (b == PAREN_BYTE) begin
        esc_phase = ESC_GOT_PAREN;
      end else begin
        res[0] = ESC_BYTE;
        res[1] = DOLLAR_BYTE;
        res[2] = b;
        n = 3;
        esc_phase = ESC_NONE;
      end
    end else if (esc_phase == ESC_GOT_PAREN) begin
      if (b == C_BYTE) begin
        kr_designated = 1'b1;
      end else begin
        res[0] = ESC_BYTE;
        res[1] = DOLLAR_BYTE;
        res[2] = PAREN_BYTE;
        res[3] = b;
        n = 4;
      end
      esc_phase = ESC_NONE;
    end else if (lead_held) begin
      // a held lead takes any byte as its trail, control bytes too
      res[0] = lead_byte | HIGH_BIT;
      res[1] = b | HIGH_BIT;
      n = 2;
      lead_held = 1'b0;
    end else if (b == ESC_BYTE) begin
      esc_phase = ESC_GOT_ESC;
    end else if (b == SO_BYTE) begin
      kr_shifted = 1'b1;
    end else if (b == SI_BYTE) begin
      kr_shifted = 1'b0;
    end else if (kr_designated && kr_shifted) begin
      lead_byte = b;
      lead_held = 1'b1;
    end else begin
      res[0] = b & LOW_MASK;
      n = 1;
    end
    return n;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTED)
      $display("%0t ns: mismatch: %s", $realtime, what);
  endtask

  // mostly back to back, some short gaps, a few long ones, now and then a long burst
  function automatic int pick_gap();
    int r;
    if (in_burst_left > 0) begin
      in_burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      in_burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed, input logic [2:0] cnt,
                           input logic [31:0] bytes);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    drv_typed <= typed;
    drv_cnt   <= cnt;
    drv_bytes <= bytes;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // sender holds off until the decoder has delivered everything owed
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (euc_expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] kr_lead_byte();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(8'h21, 8'h7e));
    return 8'($urandom_range(0, 255));
  endfunction

  always @(posedge clk) begin : scoreboard
    logic [3:0][7:0] pred;
    int              n;
    euc_item_t       want;
    if (rst_n && in_tvalid && in_tready) begin
      n = decode_iso_byte(in_tdata, pred);
      if (drv_typed) begin
        n = drv_cnt;
        for (int i = 0; i < 4; i++) pred[i] = drv_bytes[31 - 8 * i -: 8];
      end
      for (int i = 0; i < n; i++) euc_expected_q.push_back({pred[i], i == n - 1});
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (euc_expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item byte %02h last %0b", out_tdata, out_tlast));
      end else begin
        want = euc_expected_q.pop_front();
        if (out_tdata !== want.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_tdata, want.data));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last_of_run %0b, expected %0b on byte %02h",
                                    out_tlast, want.last, want.data));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: ready runs of random length with short and occasional long stalls
  initial begin : sink
    int run;
    int gap;
    int r;
    out_tready = 1'b0;
    @(negedge clk);
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 8);
      out_tready <= 1'b1;
      repeat (run) @(negedge clk);
      r = $urandom_range(0, 19);
      gap = (r < 3) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin : stim
    logic [7:0] seq_q[$];
    int         sent;
    int         kind;
    int         depth;
    bit         paused;
    logic [7:0] specials [10];
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    drv_typed = 1'b0;
    drv_cnt   = 3'd0;
    drv_bytes = 32'h0;
    specials = '{ESC_BYTE, SO_BYTE, SI_BYTE, DOLLAR_BYTE, PAREN_BYTE, C_BYTE,
                 8'h00, 8'hff, 8'h80, 8'h7f};
    dir_tbl = '{
      {8'h41,       1'b1, 3'd1, {8'h41, 24'h0}},                         // ascii after reset
      {8'hff,       1'b1, 3'd1, {LOW_MASK, 24'h0}},                      // top bit dropped
      {8'h00,       1'b1, 3'd1, {8'h00, 24'h0}},
      {ESC_BYTE,    1'b1, 3'd0, 32'h0},
      {8'h78,       1'b1, 3'd2, {ESC_BYTE, 8'h78, 16'h0}},               // bad 2-byte escape
      {ESC_BYTE,    1'b0, 3'd0, 32'h0},
      {DOLLAR_BYTE, 1'b0, 3'd0, 32'h0},
      {8'h41,       1'b1, 3'd3, {ESC_BYTE, DOLLAR_BYTE, 8'h41, 8'h00}},  // bad 3-byte escape
      {ESC_BYTE,    1'b0, 3'd0, 32'h0},
      {DOLLAR_BYTE, 1'b0, 3'd0, 32'h0},
      {PAREN_BYTE,  1'b0, 3'd0, 32'h0},
      {8'h44,       1'b1, 3'd4, {ESC_BYTE, DOLLAR_BYTE, PAREN_BYTE, 8'h44}},
      {ESC_BYTE,    1'b0, 3'd0, 32'h0},
      {8'hff,       1'b1, 3'd2, {ESC_BYTE, 8'hff, 16'h0}},               // raw byte keeps bit 7
      {SO_BYTE,     1'b1, 3'd0, 32'h0},                                  // shift before designation
      {8'hc1,       1'b1, 3'd1, {8'h41, 24'h0}},
      {ESC_BYTE,    1'b0, 3'd0, 32'h0},
      {DOLLAR_BYTE, 1'b0, 3'd0, 32'h0},
      {PAREN_BYTE,  1'b0, 3'd0, 32'h0},
      {C_BYTE,      1'b0, 3'd0, 32'h0},                                  // now designated
      {8'h30,       1'b0, 3'd0, 32'h0},
      {8'h21,       1'b0, 3'd0, 32'h0},
      {8'h45,       1'b0, 3'd0, 32'h0},
      {ESC_BYTE,    1'b0, 3'd0, 32'h0},                                  // trail byte, not escape
      {8'hff,       1'b0, 3'd0, 32'h0},
      {SO_BYTE,     1'b0, 3'd0, 32'h0},
      {ESC_BYTE,    1'b0, 3'd0, 32'h0},                                  // escape while shifted
      {8'h5a,       1'b0, 3'd0, 32'h0},
      {SI_BYTE,     1'b0, 3'd0, 32'h0},
      {8'h41,       1'b1, 3'd1, {8'h41, 24'h0}}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(dir_tbl[i].in_b, dir_tbl[i].typed, dir_tbl[i].cnt, dir_tbl[i].bytes);
    drain_results();

    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      seq_q.delete();
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          seq_q = '{ESC_BYTE, DOLLAR_BYTE, PAREN_BYTE, C_BYTE};
        end
        1, 2, 3: begin
          // double-byte text, sometimes left shifted out
          seq_q.push_back(SO_BYTE);
          repeat ($urandom_range(1, 6)) begin
            seq_q.push_back(kr_lead_byte());
            seq_q.push_back(8'($urandom_range(0, 255)));
          end
          if ($urandom_range(0, 1) == 1) seq_q.push_back(SI_BYTE);
        end
        4, 5: begin
          repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 1) == 1) seq_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
            else seq_q.push_back(8'($urandom_range(0, 255)));
          end
        end
        6, 7: begin
          // escape cut short after one, two or three bytes
          depth = $urandom_range(0, 2);
          seq_q.push_back(ESC_BYTE);
          if (depth >= 1) seq_q.push_back(DOLLAR_BYTE);
          if (depth >= 2) seq_q.push_back(PAREN_BYTE);
          seq_q.push_back(8'($urandom_range(0, 255)));
        end
        8: begin
          seq_q.push_back(SI_BYTE);
        end
        default: begin
          repeat ($urandom_range(1, 4))
            seq_q.push_back(specials[$urandom_range(0, 9)]);
        end
      endcase
      foreach (seq_q[j]) send_byte(seq_q[j], 1'b0, 3'd0, 32'h0);
      sent += seq_q.size();
      if (!paused && sent > RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end

    in_tvalid <= 1'b0;
    while (euc_expected_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (err_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/i2k_pkg.sv
design/i2k_front.sv
design/i2k_queue.sv
design/i2k_back.sv
design/iso2022kr_to_euckr_decoder_top.sv
design/i2k_checker.sv
tb/sv/tb_top.sv
